>>> design/ptqc_pkg.sv
// Shared types and constants of the power-of-two quantizer calibrator.
`default_nettype none
package ptqc_pkg;

   localparam int MAX_CODE_BITS = 16;
   localparam int CODE_W        = 16;
   localparam int POS_W         = 9;
   localparam int POS_SAT       = 160;
   localparam int ZERO_POS      = 127;

   localparam logic [31:0] POS_INF_BITS = 32'h7F80_0000;
   localparam logic [31:0] NEG_INF_BITS = 32'hFF80_0000;

   // Register indexes (byte address divided by four).
   localparam logic [2:0] REG_BIT_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAC_POS   = 3'd1;
   localparam logic [2:0] REG_ACT_MODE   = 3'd2;
   localparam logic [2:0] REG_DPU_ROUND  = 3'd3;
   localparam logic [2:0] REG_RAISED_LOW = 3'd4;

   typedef struct packed {
      logic [4:0]        eff_width;
      logic signed [7:0] frac_pos;
      logic              act_mode;
      logic              dpu_round;
      logic              raised_low;
   } cfg_type;

   // Total order key of a numeric single-precision pattern.
   function automatic logic [31:0] order_key(input logic [31:0] b);
      order_key = b[31] ? ~b : (b | 32'h8000_0000);
   endfunction

endpackage
`default_nettype wire

>>> design/ptqc_quant.sv
// Scale, round and saturate one single-precision sample to an integer code.
`default_nettype none
module ptqc_quant
   import ptqc_pkg::*;
(
   input  cfg_type                   cfg,
   input  logic [31:0]               sample,
   output logic signed [CODE_W-1:0]  code
);

   logic [7:0]         ex;
   logic [23:0]        m;
   logic signed [9:0]  s;
   logic [9:0]         sh;
   logic               neg;
   logic               is_nan;
   logic               is_inf;
   logic [16:0]        hi_mag;
   logic [16:0]        lo_mag;
   logic [39:0]        mag;
   logic [24:0]        rem;
   logic [24:0]        half;
   logic               half_down;
   logic               sat;
   logic [16:0]        res_mag;
   logic signed [17:0] res;

   assign ex     = sample[30:23];
   assign m      = {(ex != 8'd0), sample[22:0]};
   assign neg    = sample[31];
   assign is_nan = (ex == 8'hFF) && (sample[22:0] != 23'd0);
   assign is_inf = (ex == 8'hFF) && (sample[22:0] == 23'd0);
   // Exponent of the integer mantissa plus the fraction position.
   assign s = $signed({2'b00, ex}) - 10'sd150 + $signed({9'd0, (ex == 8'd0)})
              + $signed({{2{cfg.frac_pos[7]}}, cfg.frac_pos});
   assign sh = 10'd0 - s;

   assign hi_mag = (17'd1 << (cfg.eff_width - 5'd1)) - 17'd1;
   assign lo_mag = (17'd1 << (cfg.eff_width - 5'd1))
                   - {16'd0, cfg.act_mode & cfg.raised_low};
   assign half_down = neg & cfg.act_mode & cfg.dpu_round;

   always_comb begin
      mag  = 40'd0;
      sat  = 1'b0;
      rem  = 25'd0;
      half = 25'd0;
      if (is_inf) begin
         sat = 1'b1;
      end else if (!is_nan && m != 24'd0) begin
         if (!s[9]) begin
            if (s > 10'sd15) sat = 1'b1;
            else mag = {16'd0, m} << s[3:0];
         end else if (sh < 10'd25) begin
            rem  = {1'b0, m} & ((25'd1 << sh[4:0]) - 25'd1);
            half = 25'd1 << (sh[4:0] - 5'd1);
            mag  = {16'd0, m >> sh[4:0]};
            if (rem > half || (rem == half && !half_down)) mag = mag + 40'd1;
         end
      end
      if (neg) begin
         res_mag = (sat || mag > {23'd0, lo_mag}) ? lo_mag : mag[16:0];
      end else begin
         res_mag = (sat || mag > {23'd0, hi_mag}) ? hi_mag : mag[16:0];
      end
      res  = neg ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
      code = res[CODE_W-1:0];
   end

endmodule
`default_nettype wire

>>> design/ptqc_calib.sv
// Overflow-safe fraction position from the running minimum and maximum.
`default_nettype none
module ptqc_calib
   import ptqc_pkg::*;
(
   input  logic [4:0]               eff_width,
   input  logic [31:0]              run_min,
   input  logic [31:0]              run_max,
   output logic signed [POS_W-1:0]  pos,
   output logic                     all_zero
);

   // Largest p with 2*m*2^(e+p) <= d, where dn is d aligned to bit 23
   // and bd is the bit length of d.
   function automatic logic signed [10:0] side_pos(input logic [31:0] b,
                                                  input logic [23:0] dn,
                                                  input logic [4:0]  bd);
      logic [7:0]         ex;
      logic [23:0]        m;
      logic [23:0]        mn;
      logic [4:0]         lm;
      logic signed [10:0] e;
      logic               gt;
      ex = b[30:23];
      m  = {(ex != 8'd0), b[22:0]};
      e  = (ex == 8'd0) ? -11'sd149 : $signed({3'd0, ex}) - 11'sd150;
      lm = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (m[i]) lm = 5'(i + 1);
      end
      mn = m << (5'd24 - lm);
      gt = mn > dn;
      side_pos = $signed({6'd0, bd}) - $signed({6'd0, lm})
                 - $signed({10'd0, gt}) - e - 11'sd1;
   endfunction

   logic               min_ok;
   logic               max_ok;
   logic               min_inf;
   logic               max_inf;
   logic [23:0]        dn_min;
   logic [23:0]        dn_max;
   logic signed [10:0] p_min;
   logic signed [10:0] p_max;
   logic signed [10:0] best;

   assign min_ok  = run_min[31] && (run_min[30:0] != 31'd0);
   assign max_ok  = !run_max[31] && (run_max[30:0] != 31'd0);
   assign min_inf = run_min[30:0] == 31'h7F80_0000;
   assign max_inf = run_max[30:0] == 31'h7F80_0000;
   assign dn_min  = 24'h80_0000 | (24'h80_0000 >> eff_width);
   assign dn_max  = 24'hFF_FFFF << (5'd24 - eff_width);
   assign p_min   = side_pos(run_min, dn_min, eff_width + 5'd1);
   assign p_max   = side_pos(run_max, dn_max, eff_width);

   always_comb begin
      all_zero = 1'b0;
      if (min_ok && max_ok) best = (p_max < p_min) ? p_max : p_min;
      else if (min_ok)      best = p_min;
      else                  best = p_max;
      if ((min_ok && min_inf) || (max_ok && max_inf)) begin
         pos = -POS_W'(POS_SAT);
      end else if (min_ok || max_ok) begin
         if (best > 11'(POS_SAT))       pos = POS_W'(POS_SAT);
         else if (best < -11'(POS_SAT)) pos = -POS_W'(POS_SAT);
         else                           pos = best[POS_W-1:0];
      end else begin
         pos      = POS_W'(ZERO_POS);
         all_zero = 1'b1;
      end
   end

endmodule
`default_nettype wire

>>> design/power_of_two_quantizer_calibrator.sv
// Top level of the power-of-two quantizer with overflow-safe position calibration.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | sample_bits, is_last
//   rsp     | out       | rsp_valid/stall    | code, last_out, overflow_pos, all_zero
//   csr     | in/out    | APB write and read | five configuration registers
//
// A transferred sample is held in the input register; its result is loaded into the result
// register when the input register moves on and is offered from there. One sample per
// cycle is sustained while rsp_stall stays low.
// The running min/max update and the position calculation share the input stage cycle.
// Synchronous reset clears the valid flags and the min/max state and loads the
// configuration registers with their defaults.
// A stalled result holds while the input register still takes one more sample.
`default_nettype none
module power_of_two_quantizer_calibrator
   import ptqc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [31:0]               req_sample_bits,
   input  logic                      req_is_last,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [CODE_W-1:0]  rsp_code,
   output logic                      rsp_last_out,
   output logic signed [POS_W-1:0]   rsp_overflow_pos,
   output logic                      rsp_all_zero,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [4:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   logic [4:0]        bit_width_ff;
   logic signed [7:0] frac_pos_ff;
   logic              act_mode_ff;
   logic              dpu_round_ff;
   logic              raised_low_ff;
   cfg_type           cfg;
   logic              csr_wr;

   logic              a_valid_ff;
   logic [31:0]       a_sample_ff;
   logic              a_last_ff;
   logic              b_valid_ff;
   logic signed [CODE_W-1:0] b_code_ff;
   logic              b_last_ff;
   logic signed [POS_W-1:0]  b_pos_ff;
   logic              b_zero_ff;
   logic [31:0]       run_min_ff;
   logic [31:0]       run_max_ff;
   logic [31:0]       run_min_in;
   logic [31:0]       run_max_in;
   logic [31:0]       upd_min;
   logic [31:0]       upd_max;

   logic              b_free;
   logic              a_move;
   logic              req_take;
   logic              a_nan;
   logic signed [CODE_W-1:0] q_code;
   logic signed [POS_W-1:0]  c_pos;
   logic              c_zero;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_width_ff  <= 5'd8;
         frac_pos_ff   <= 8'sd0;
         act_mode_ff   <= 1'b0;
         dpu_round_ff  <= 1'b1;
         raised_low_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_BIT_WIDTH:  bit_width_ff  <= csr_pwdata[4:0];
            REG_FRAC_POS:   frac_pos_ff   <= csr_pwdata[7:0];
            REG_ACT_MODE:   act_mode_ff   <= csr_pwdata[0];
            REG_DPU_ROUND:  dpu_round_ff  <= csr_pwdata[0];
            REG_RAISED_LOW: raised_low_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_BIT_WIDTH:  csr_prdata = {27'd0, bit_width_ff};
         REG_FRAC_POS:   csr_prdata = {24'd0, frac_pos_ff};
         REG_ACT_MODE:   csr_prdata = {31'd0, act_mode_ff};
         REG_DPU_ROUND:  csr_prdata = {31'd0, dpu_round_ff};
         REG_RAISED_LOW: csr_prdata = {31'd0, raised_low_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_comb begin
      if (bit_width_ff < 5'd2)                       cfg.eff_width = 5'd2;
      else if (bit_width_ff > 5'(MAX_CODE_BITS))     cfg.eff_width = 5'(MAX_CODE_BITS);
      else                                           cfg.eff_width = bit_width_ff;
      cfg.frac_pos   = frac_pos_ff;
      cfg.act_mode   = act_mode_ff;
      cfg.dpu_round  = dpu_round_ff;
      cfg.raised_low = raised_low_ff;
   end

   // Handshake: the input register moves on whenever the result register frees up.
   assign b_free    = !b_valid_ff || !rsp_stall;
   assign a_move    = a_valid_ff && b_free;
   assign req_stall = a_valid_ff && !b_free;
   assign req_take  = req_valid && !req_stall;

   // Min/max including the sample now in the input register.
   assign a_nan = (a_sample_ff[30:23] == 8'hFF) && (a_sample_ff[22:0] != 23'd0);
   always_comb begin
      upd_min = run_min_ff;
      upd_max = run_max_ff;
      if (!a_nan) begin
         if (order_key(a_sample_ff) < order_key(run_min_ff)) upd_min = a_sample_ff;
         if (order_key(a_sample_ff) > order_key(run_max_ff)) upd_max = a_sample_ff;
      end
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      if (a_move) begin
         run_min_in = a_last_ff ? POS_INF_BITS : upd_min;
         run_max_in = a_last_ff ? NEG_INF_BITS : upd_max;
      end
   end

   ptqc_quant u_quant (
      .cfg    (cfg),
      .sample (a_sample_ff),
      .code   (q_code)
   );

   ptqc_calib u_calib (
      .eff_width (cfg.eff_width),
      .run_min   (upd_min),
      .run_max   (upd_max),
      .pos       (c_pos),
      .all_zero  (c_zero)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         run_min_ff <= POS_INF_BITS;
         run_max_ff <= NEG_INF_BITS;
      end else begin
         if (req_take)    a_valid_ff <= 1'b1;
         else if (a_move) a_valid_ff <= 1'b0;
         if (a_move)      b_valid_ff <= 1'b1;
         else if (b_free) b_valid_ff <= 1'b0;
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_sample_ff <= req_sample_bits;
         a_last_ff   <= req_is_last;
      end
      if (a_move) begin
         b_code_ff <= q_code;
         b_last_ff <= a_last_ff;
         b_pos_ff  <= a_last_ff ? c_pos : '0;
         b_zero_ff <= a_last_ff & c_zero;
      end
   end

   assign rsp_valid        = b_valid_ff;
   assign rsp_code         = b_code_ff;
   assign rsp_last_out     = b_last_ff;
   assign rsp_overflow_pos = b_pos_ff;
   assign rsp_all_zero     = b_zero_ff;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench of the power-of-two quantizer calibrator with a local predictor.
`default_nettype none
module tb;
   import ptqc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_sample_bits = '0;
   logic req_is_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [CODE_W-1:0] rsp_code;
   logic rsp_last_out;
   logic signed [POS_W-1:0] rsp_overflow_pos;
   logic rsp_all_zero;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   power_of_two_quantizer_calibrator DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   typedef struct packed {
      logic signed [15:0] code;
      logic               last_out;
      logic signed [8:0]  pos;
      logic               zero;
   } quant_result_type;

   quant_result_type quant_results_q[$];
   int errors = 0;
   int idle_cycles = 0;

   // Predictor copy of configuration and tensor state.
   logic [4:0] p_bw;
   logic signed [7:0] p_frac;
   logic p_act, p_dpu, p_raised;
   logic [31:0] p_min, p_max;

   function automatic bit f_nan(logic [31:0] b);
      return b[30:23] == 8'hFF && b[22:0] != 0;
   endfunction

   function automatic bit f_inf(logic [31:0] b);
      return b[30:23] == 8'hFF && b[22:0] == 0;
   endfunction

   function automatic int width_clamped();
      int w;
      w = int'(p_bw);
      if (w < 2) w = 2;
      if (w > MAX_CODE_BITS) w = MAX_CODE_BITS;
      return w;
   endfunction

   function automatic void split(logic [31:0] b, output longint unsigned m, output int e);
      if (b[30:23] == 0) begin
         m = 64'(b[22:0]);
         e = -149;
      end else begin
         m = 64'({1'b1, b[22:0]});
         e = int'(b[30:23]) - 150;
      end
   endfunction

   function automatic int bit_length(longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
         v >>= 1;
         n++;
      end
      return n;
   endfunction

   // Largest p with 2*|x|*2^p <= d.
   function automatic longint fit_pos(longint unsigned m, int e, longint unsigned d);
      int t;
      bit fits;
      t = bit_length(d) - bit_length(m) + 1;
      forever begin
         if (t >= 0) fits = (m << t) <= d;
         else fits = m <= (d << (-t));
         if (fits) break;
         t--;
      end
      return longint'(t) - e - 1;
   endfunction

   function automatic longint quantize_sample(logic [31:0] b);
      int w, s, sh;
      longint hi, lo, v;
      longint unsigned m, mag, rem, half;
      int e;
      bit neg;
      w = width_clamped();
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -(64'sd1 <<< (w - 1));
      neg = b[31];
      if (p_act && p_raised) lo += 1;
      if (f_nan(b)) return 0;
      if (f_inf(b)) return neg ? lo : hi;
      split(b, m, e);
      s = e + int'(p_frac);
      if (m == 0) return 0;
      if (s >= 0) begin
         if (s > 39) return neg ? lo : hi;
         mag = m << s;
      end else begin
         sh = -s;
         if (sh >= 25) mag = 0;
         else begin
            rem = m & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            mag = m >> sh;
            if (rem > half) mag++;
            else if (rem == half && !(neg && p_act && p_dpu)) mag++;
         end
      end
      v = neg ? -longint'(mag) : longint'(mag);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic quant_result_type predict_sample(logic [31:0] b, logic last);
      quant_result_type r;
      longint best, p;
      longint unsigned m;
      int e, w;
      bit have, inf_seen;
      r = '0;
      r.code = 16'(quantize_sample(b));
      r.last_out = last;
      if (!f_nan(b)) begin
         if (order_key(b) < order_key(p_min)) p_min = b;
         if (order_key(b) > order_key(p_max)) p_max = b;
      end
      if (last) begin
         w = width_clamped();
         have = 0;
         inf_seen = 0;
         best = 0;
         if (p_min[31] && p_min[30:0] != 0) begin
            if (f_inf(p_min)) inf_seen = 1;
            else begin
               split(p_min, m, e);
               best = fit_pos(m, e, (64'd1 << w) + 1);
               have = 1;
            end
         end
         if (!p_max[31] && p_max[30:0] != 0) begin
            if (f_inf(p_max)) inf_seen = 1;
            else begin
               split(p_max, m, e);
               p = fit_pos(m, e, (64'd1 << w) - 1);
               if (!have || p < best) best = p;
               have = 1;
            end
         end
         if (inf_seen) r.pos = -9'(POS_SAT);
         else if (have) begin
            if (best > POS_SAT) best = POS_SAT;
            if (best < -POS_SAT) best = -POS_SAT;
            r.pos = 9'(best);
         end else begin
            r.pos = 9'(ZERO_POS);
            r.zero = 1'b1;
         end
         p_min = POS_INF_BITS;
         p_max = NEG_INF_BITS;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // Checks each result transfer against the oldest expectation.
   always @(posedge clock) begin
      quant_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (quant_results_q.size() == 0) report_mismatch("unexpected result", rsp_code, 0);
         else begin
            want = quant_results_q.pop_front();
            if (rsp_code !== want.code) report_mismatch("code", rsp_code, want.code);
            if (rsp_last_out !== want.last_out)
               report_mismatch("last_out", rsp_last_out, want.last_out);
            if (rsp_overflow_pos !== want.pos)
               report_mismatch("overflow_pos", rsp_overflow_pos, want.pos);
            if (rsp_all_zero !== want.zero) report_mismatch("all_zero", rsp_all_zero, want.zero);
         end
      end
   end

   // Receiver stall pattern, with quiet stretches.
   int stall_mode = 0;
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   int burst_left = 0;

   task automatic send_sample(logic [31:0] b, logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample_bits <= b;
      req_is_last <= last;
      quant_results_q.push_back(predict_sample(b, last));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (quant_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_BIT_WIDTH: p_bw = val[4:0];
         REG_FRAC_POS: p_frac = val[7:0];
         REG_ACT_MODE: p_act = val[0];
         REG_DPU_ROUND: p_dpu = val[0];
         REG_RAISED_LOW: p_raised = val[0];
         default: ;
      endcase
   endtask

   task automatic set_config(int bw, int fp, bit act, bit dpu, bit raised);
      write_reg(REG_BIT_WIDTH, bw);
      write_reg(REG_FRAC_POS, fp);
      write_reg(REG_ACT_MODE, {31'd0, act});
      write_reg(REG_DPU_ROUND, {31'd0, dpu});
      write_reg(REG_RAISED_LOW, {31'd0, raised});
   endtask

   // Random sample biased toward values that land in the code range.
   function automatic logic [31:0] random_sample();
      logic [31:0] b;
      int k;
      b = $urandom;
      k = $urandom_range(0, 9);
      if (k < 7) b[30:23] = 8'(127 - int'(p_frac) + $urandom_range(0, 20) - 12);
      else if (k == 7) b[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else if (k == 8) b[22:0] = $urandom_range(0, 1) ? 23'h400000 : 23'h0;
      return b;
   endfunction

   task automatic test_directed_defaults();
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h3F00_0000, 1'b0);
      send_sample(32'hBF00_0000, 1'b0);
      send_sample(32'h3FC0_0000, 1'b0);
      send_sample(32'hBFC0_0000, 1'b0);
      send_sample(32'h7F80_0000, 1'b0);
      send_sample(32'hFF80_0000, 1'b1);
      send_sample(32'h7FC0_0001, 1'b1);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h7F7F_FFFF, 1'b0);
      send_sample(32'h0000_0001, 1'b1);
      send_sample(32'h42FE_0000, 1'b0);
      send_sample(32'hC300_0000, 1'b1);
      send_sample(32'h7F80_0000, 1'b1);
      drain();
   endtask

   task automatic test_activation_rounding();
      set_config(4, 1, 1'b1, 1'b1, 1'b1);
      send_sample(32'hBE80_0000, 1'b0);
      send_sample(32'h3E80_0000, 1'b0);
      send_sample(32'hC2C8_0000, 1'b0);
      send_sample(32'h3F40_0000, 1'b1);
      drain();
      set_config(0, -128, 1'b1, 1'b0, 1'b0);
      send_sample(32'hFF7F_FFFF, 1'b0);
      send_sample(32'h0080_0000, 1'b1);
      drain();
      set_config(31, 127, 1'b0, 1'b1, 1'b0);
      send_sample(32'h0000_0003, 1'b0);
      send_sample(32'h8000_0001, 1'b1);
      drain();
   endtask

   task automatic test_random_tensors();
      int n, bw, fp;
      for (int phase = 0; phase < 9; phase++) begin
         bw = (phase == 0) ? 2 : (phase == 1) ? 16 : $urandom_range(0, 31);
         fp = (phase == 2) ? -128 : (phase == 3) ? 127 : int'($urandom_range(0, 40)) - 20;
         set_config(bw, fp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
         n = 0;
         while (n < 50) begin
            send_sample(random_sample(), $urandom_range(0, 9) == 0);
            n++;
         end
         send_sample(random_sample(), 1'b1);
         drain();
      end
   endtask

   initial begin
      p_bw = 8;
      p_frac = 0;
      p_act = 0;
      p_dpu = 1;
      p_raised = 0;
      p_min = POS_INF_BITS;
      p_max = NEG_INF_BITS;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_defaults();
      test_activation_rounding();
      test_random_tensors();
      repeat (10) @(posedge clock);
      if (errors == 0 && quant_results_q.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
